### rtl/xb64_pkg.sv
`default_nettype none

package xb64_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_KEY_LOW  = 2'd0,
        CFG_KEY_HIGH = 2'd1,
        CFG_KEY_LEN  = 2'd2,
        CFG_UNUSED   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } out_item_t;

    // One character slot: a six-bit code or a pad character
    typedef struct packed {
        logic       pad;
        logic [5:0] sextet;
    } slot_t;

    // Work for the back end produced by one input byte
    typedef struct packed {
        slot_t [3:0] slot;
        logic  [1:0] last_idx;
        logic        last;
    } cmd_t;

    // Front-end state as seen from the top level
    typedef struct packed {
        logic [3:0] key_position;
        logic [1:0] group_phase;
    } front_stat_t;

endpackage

`default_nettype wire

### rtl/xor_base64_encoder.sv
`default_nettype none

// Repeating-key XOR plus base64 encoder. Message bytes go in through a queue-style
// port (push/full, with last_byte on the final byte); each byte is XORed with the
// key byte at the running key position, which wraps at key_length (0 reads as 1,
// values above KEY_BYTES read as KEY_BYTES) and restarts with every message. The
// result comes out as standard base64 characters on a queue-style port
// (empty/pop), with the leftover bits flushed and '=' padding on the last byte,
// and last_char set on the final character. Configuration writes take effect at
// once (cfg_ready is always high) and belong between messages. The front
// end takes one byte per cycle while its two-entry command queue has room; the
// back end emits one character per cycle from a single output register while
// the receiver pops it. A plain byte yields one or two characters and a last
// byte up to four, about 1.33 characters per byte on long messages. A byte
// enters the queue the cycle it is accepted; its first character passes from
// the queue entry into the output register before it is visible.

module xor_base64_encoder
    import xb64_pkg::*;
#(
    parameter int KEY_BYTES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire in_item_t    in_item,
    output logic             empty,
    input  wire logic        pop,
    output out_item_t        out_item,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire cfg_index_t  cfg_index,
    input  wire logic [63:0] cfg_data
);

    logic        accept;
    logic        q_full, q_empty, q_pop;
    cmd_t        front_cmd, q_cmd;
    front_stat_t front_stat;

    // Register writes never stall
    assign cfg_ready = 1'b1;

    // A byte transfers whenever the command queue has a free entry
    assign full   = q_full;
    assign accept = push && !q_full;

    // Front end: key XOR, group phase tracking, slot generation
    xb64_front #(
        .KEY_BYTES (KEY_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .in_item   (in_item),
        .cmd       (front_cmd),
        .stat      (front_stat)
    );

    // Decouple the two ends so either can stall alone
    xb64_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_cmd  (front_cmd),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_cmd  (q_cmd),
        .q_empty (q_empty)
    );

    // Back end: walk the slots, map to ASCII, hold in the output register
    xb64_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .out_item (out_item)
    );

    // A full queue always has work for the back end
    a_full_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_empty)
        else $error("queue full but reported empty");

    // Last byte returns the front end to the start of a message
    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_item.last_byte |=>
            (front_stat.group_phase == 2'd0) && (front_stat.key_position == 4'd0))
        else $error("front state not cleared after last byte");

    // Key position stays inside the stored key
    a_key_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, front_stat.key_position} < 5'(KEY_BYTES))
        else $error("key position beyond stored key");

endmodule

`default_nettype wire

### rtl/xb64_front.sv
`default_nettype none

module xb64_front
    import xb64_pkg::*;
#(
    parameter int KEY_BYTES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire cfg_index_t  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        accept,
    input  wire in_item_t    in_item,
    output cmd_t             cmd,
    output front_stat_t      stat
);

    localparam logic [4:0] KEY_LEN_MAX = 5'(KEY_BYTES);

    logic [KEY_BYTES-1:0][7:0] key_reg;
    logic [4:0]                key_len_reg;
    logic [3:0]                key_pos_reg, key_pos_next;
    logic [3:0]                left_reg, left_next;
    logic [1:0]                phase_reg, phase_next;

    logic [7:0] key_sel;
    logic [7:0] b;
    logic [4:0] eff_len;
    logic [4:0] pos_inc;

    // Key storage: only the bytes that can ever be used
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg     <= '0;
            key_len_reg <= 5'd16;
        end
        else if (cfg_we)
        begin
            for (int i = 0; i < KEY_BYTES; i++)
            begin
                if (i < 8 && cfg_index == CFG_KEY_LOW)
                    key_reg[i] <= cfg_data[8*(i%8) +: 8];
                if (i >= 8 && cfg_index == CFG_KEY_HIGH)
                    key_reg[i] <= cfg_data[8*(i%8) +: 8];
            end
            if (cfg_index == CFG_KEY_LEN)
                key_len_reg <= cfg_data[4:0];
        end
    end

    always_comb
    begin
        key_sel = '0;
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            if (key_pos_reg == 4'(i))
                key_sel = key_reg[i];
        end
    end

    always_comb
    begin
        if (key_len_reg == 5'd0)
            eff_len = 5'd1;
        else if (key_len_reg > KEY_LEN_MAX)
            eff_len = KEY_LEN_MAX;
        else
            eff_len = key_len_reg;
    end

    assign b       = in_item.data_byte ^ key_sel;
    assign pos_inc = {1'b0, key_pos_reg} + 5'd1;

    // Classify the byte by group phase and build the character slots
    always_comb
    begin
        cmd          = '0;
        left_next    = left_reg;
        phase_next   = phase_reg;
        key_pos_next = (pos_inc >= eff_len) ? 4'd0 : pos_inc[3:0];

        case (phase_reg)
            2'd1:
            begin
                cmd.slot[0].sextet = {left_reg[1:0], b[7:4]};
                left_next          = b[3:0];
                phase_next         = 2'd2;
                cmd.last_idx       = 2'd0;
            end
            2'd2:
            begin
                cmd.slot[0].sextet = {left_reg[3:0], b[7:6]};
                cmd.slot[1].sextet = b[5:0];
                left_next          = 4'd0;
                phase_next         = 2'd0;
                cmd.last_idx       = 2'd1;
            end
            default:
            begin
                cmd.slot[0].sextet = b[7:2];
                left_next          = {2'b00, b[1:0]};
                phase_next         = 2'd1;
                cmd.last_idx       = 2'd0;
            end
        endcase

        // Flush leftover bits and pad to a full quad on the last byte
        if (in_item.last_byte)
        begin
            cmd.last = 1'b1;
            if (phase_next == 2'd1)
            begin
                cmd.slot[1].sextet = {left_next[1:0], 4'b0000};
                cmd.slot[2].pad    = 1'b1;
                cmd.slot[3].pad    = 1'b1;
                cmd.last_idx       = 2'd3;
            end
            else if (phase_next == 2'd2)
            begin
                cmd.slot[1].sextet = {left_next[3:0], 2'b00};
                cmd.slot[2].pad    = 1'b1;
                cmd.last_idx       = 2'd2;
            end
            left_next    = 4'd0;
            phase_next   = 2'd0;
            key_pos_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_pos_reg <= 4'd0;
            left_reg    <= 4'd0;
            phase_reg   <= 2'd0;
        end
        else if (accept)
        begin
            key_pos_reg <= key_pos_next;
            left_reg    <= left_next;
            phase_reg   <= phase_next;
        end
    end

    assign stat.key_position = key_pos_reg;
    assign stat.group_phase  = phase_reg;

endmodule

`default_nettype wire

### rtl/xb64_queue.sv
`default_nettype none

module xb64_queue
    import xb64_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire cmd_t wr_cmd,
    output logic      q_full,
    input  wire logic rd_en,
    output cmd_t      rd_cmd,
    output logic      q_empty
);

    cmd_t [1:0] mem_reg;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign rd_cmd  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_cmd;
    end

endmodule

`default_nettype wire

### rtl/xb64_back.sv
`default_nettype none

module xb64_back
    import xb64_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_empty,
    input  wire cmd_t q_cmd,
    output logic      q_pop,
    input  wire logic pop,
    output logic      empty,
    output out_item_t out_item
);

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26)
            return w + 8'd65;
        else if (v < 6'd52)
            return w + 8'd71;
        else if (v < 6'd62)
            return w - 8'd4;
        else if (v == 6'd62)
            return 8'h2B;
        else
            return 8'h2F;
    endfunction

    logic      out_valid_reg, out_valid_next;
    out_item_t out_reg;
    logic [1:0] idx_reg, idx_next;
    logic      load, take;
    slot_t     cur;

    assign load  = !out_valid_reg || pop;
    assign take  = load && !q_empty;
    assign cur   = q_cmd.slot[idx_reg];
    assign q_pop = take && (idx_reg == q_cmd.last_idx);

    always_comb
    begin
        if (q_pop)
            idx_next = 2'd0;
        else if (take)
            idx_next = idx_reg + 2'd1;
        else
            idx_next = idx_reg;

        if (take)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg.out_char  <= cur.pad ? PAD_CHAR : b64_char(cur.sextet);
            out_reg.last_char <= q_cmd.last && (idx_reg == q_cmd.last_idx);
        end
    end

    assign empty    = !out_valid_reg;
    assign out_item = out_reg;

endmodule

`default_nettype wire

### tb/xor_base64_encoder_test.sv
`default_nettype none

module xor_base64_encoder_test;
    import xb64_pkg::*;

    // Generous ceiling on the whole run.
    localparam int CYCLE_LIMIT = 200000;
    localparam int KEY_SLOTS = 16;

    // Group phase: number of bytes already taken in the current 3-byte group
    localparam logic [1:0] PHASE_NONE = 2'd0;
    localparam logic [1:0] PHASE_ONE  = 2'd1;
    localparam logic [1:0] PHASE_TWO  = 2'd2;

    localparam logic [7:0] PAD_CHAR = "=";

    logic         clk = 1'b0;
    logic         rst_n;
    logic         push;
    logic         full;
    in_item_t     in_item;
    logic         empty;
    logic         pop;
    out_item_t    out_item;
    logic         cfg_valid;
    logic         cfg_ready;
    cfg_index_t   cfg_index;
    logic [63:0]  cfg_data;

    // Shadow copy of the block's registers and running state
    logic [127:0] key_bits;
    logic [4:0]   key_len;
    logic [3:0]   key_pos;
    logic [3:0]   leftover;
    logic [1:0]   phase;

    out_item_t    pending_chars[$];
    int unsigned  mismatch_count;
    int unsigned  bytes_sent;
    int unsigned  cycle_count;
    int unsigned  hold_off;
    bit           idling;

    xor_base64_encoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Map a six-bit code onto the standard base64 alphabet.
    function automatic logic [7:0] sextet_char(input logic [5:0] code);
        if (code < 6'd26)
            return "A" + {2'b00, code};
        if (code < 6'd52)
            return "a" + {2'b00, code} - 8'd26;
        if (code < 6'd62)
            return "0" + {2'b00, code} - 8'd52;
        if (code == 6'd62)
            return "+";
        return "/";
    endfunction

    function automatic void queue_char(input logic [7:0] ch);
        out_item_t item;
        item.out_char = ch;
        item.last_char = 1'b0;
        pending_chars = {pending_chars, item};
    endfunction

    // Predict the characters one accepted byte yields and advance the shadow state.
    function automatic void encode_byte(input in_item_t item);
        logic [7:0] mixed;
        logic [4:0] span;
        logic [4:0] next_pos;
        mixed = item.data_byte ^ key_bits[key_pos * 8 +: 8];

        // A zero length acts as one; anything beyond the key store acts as its size.
        span = key_len;
        if (span == 5'd0)
            span = 5'd1;
        if (span > KEY_SLOTS)
            span = 5'(KEY_SLOTS);
        next_pos = {1'b0, key_pos} + 5'd1;
        key_pos = (next_pos >= span) ? 4'd0 : next_pos[3:0];

        // Phase three cannot arise; it falls into the first-byte branch.
        case (phase)
            PHASE_ONE:
            begin
                queue_char(sextet_char({leftover[1:0], mixed[7:4]}));
                leftover = mixed[3:0];
                phase = PHASE_TWO;
            end
            PHASE_TWO:
            begin
                queue_char(sextet_char({leftover, mixed[7:6]}));
                queue_char(sextet_char(mixed[5:0]));
                leftover = 4'd0;
                phase = PHASE_NONE;
            end
            default:
            begin
                queue_char(sextet_char(mixed[7:2]));
                leftover = {2'b00, mixed[1:0]};
                phase = PHASE_ONE;
            end
        endcase

        // Flush leftover bits, pad to a multiple of four, restart the key.
        if (item.last_byte)
        begin
            if (phase == PHASE_ONE)
            begin
                queue_char(sextet_char({leftover[1:0], 4'b0000}));
                queue_char(PAD_CHAR);
                queue_char(PAD_CHAR);
            end
            else if (phase == PHASE_TWO)
            begin
                queue_char(sextet_char({leftover, 2'b00}));
                queue_char(PAD_CHAR);
            end
            pending_chars[$].last_char = 1'b1;
            key_pos = 4'd0;
            leftover = 4'd0;
            phase = PHASE_NONE;
        end
    endfunction

    // Offer one byte until the block takes it. Returns at the rising edge of
    // the transfer with push still high, so back-to-back bytes keep it high.
    task automatic send_byte(input logic [7:0] value, input logic last);
        in_item_t item;
        item.data_byte = value;
        item.last_byte = last;
        @(negedge clk);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        push <= 1'b1;
        in_item <= item;
        @(posedge clk);
        while (full)
            @(posedge clk);
        encode_byte(item);
        bytes_sent++;
    endtask

    task automatic send_message(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_byte(8'($urandom), i == len - 1);
    endtask

    // Drop push and hold until every predicted character has been popped,
    // then wait for the pipeline to go quiet.
    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // One register transfer on the configuration channel; call only when idle.
    task automatic write_reg(input cfg_index_t index, input logic [63:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (index)
            CFG_KEY_LOW:  key_bits[63:0] = value;
            CFG_KEY_HIGH: key_bits[127:64] = value;
            CFG_KEY_LEN:  key_len = value[4:0];
            default:      ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Load a fresh random key and a length drawn toward the edges, with the
    // unused upper bits of the length word random too.
    task automatic shuffle_key();
        logic [63:0] len_word;
        len_word = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       len_word[4:0] = 5'd0;
            1:       len_word[4:0] = 5'd1;
            2:       len_word[4:0] = 5'd16;
            3:       len_word[4:0] = 5'($urandom_range(17, 31));
            default: len_word[4:0] = 5'($urandom_range(2, 15));
        endcase
        settle();
        write_reg(CFG_KEY_LOW, {$urandom, $urandom});
        write_reg(CFG_KEY_HIGH, {$urandom, $urandom});
        write_reg(CFG_KEY_LEN, len_word);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_UNUSED, {$urandom, $urandom});
    endtask

    // Reset key is all zero with length 16, so bytes pass through unchanged:
    // cover the one-, two- and three-byte tails with extreme byte values.
    task automatic test_default_key();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    // Short keys wrap inside a message and restart with the next one; a zero
    // length acts as one, a length past the store acts as 16, and writes to
    // the unused index change nothing.
    task automatic test_key_lengths();
        settle();
        write_reg(CFG_KEY_LOW, 64'h0123_4567_89AB_CDEF);
        write_reg(CFG_KEY_HIGH, 64'hFEDC_BA98_7654_3210);
        write_reg(CFG_KEY_LEN, 64'd3);
        write_reg(CFG_UNUSED, '1);
        send_message(5);
        send_message(2);
        settle();
        write_reg(CFG_KEY_LEN, 64'd0);
        send_message(3);
        settle();
        write_reg(CFG_KEY_LEN, {59'h0, 5'd31});
        send_message(4);
    endtask

    // Hold the receiver off long enough that the block fills and stalls
    // transfers on its input, then pause the sender until all has drained.
    task automatic test_backpressure();
        shuffle_key();
        hold_off = 60;
        send_message(30);
        settle();
        hold_off = 40;
        send_message(12);
        send_message(1);
        settle();
    endtask

    // Random messages, mostly short, now and then long, with key changes
    // between some of them.
    task automatic test_random_messages();
        while (bytes_sent < 260)
        begin
            if ($urandom_range(0, 4) == 0)
                shuffle_key();
            if ($urandom_range(0, 7) == 0)
                send_message($urandom_range(20, 40));
            else
                send_message($urandom_range(1, 8));
        end
    endtask

    // Closing stretch with both sides running flat out.
    task automatic test_steady_stream();
        shuffle_key();
        idling = 1'b0;
        while (bytes_sent < 320)
            send_message($urandom_range(1, 12));
    endtask

    // Result side: pop low during a requested hold-off or a random burst,
    // high otherwise.
    initial
    begin : result_drain
        int unsigned burst_left;
        burst_left = 0;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                pop <= 1'b0;
                hold_off--;
            end
            else if (burst_left > 0)
            begin
                pop <= 1'b0;
                burst_left--;
            end
            else if (idling && $urandom_range(0, 5) == 0)
            begin
                pop <= 1'b0;
                burst_left = $urandom_range(0, 3);
            end
            else
                pop <= 1'b1;
        end
    end

    // Compare every popped character against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_chars.size() == 0)
            begin
                $display("%0t: unexpected character: expected none, actual %h last %b",
                         $time, out_item.out_char, out_item.last_char);
                mismatch_count++;
            end
            else
            begin
                out_item_t want;
                want = pending_chars.pop_front();
                if (out_item.out_char !== want.out_char)
                begin
                    $display("%0t: out_char expected %h actual %h",
                             $time, want.out_char, out_item.out_char);
                    mismatch_count++;
                end
                if (out_item.last_char !== want.last_char)
                begin
                    $display("%0t: last_char expected %b actual %b",
                             $time, want.last_char, out_item.last_char);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: a stuck handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_KEY_LOW;
        cfg_data = '0;
        key_bits = '0;
        key_len = 5'd16;
        key_pos = 4'd0;
        leftover = 4'd0;
        phase = PHASE_NONE;
        mismatch_count = 0;
        bytes_sent = 0;
        cycle_count = 0;
        hold_off = 0;
        idling = 1'b1;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_default_key();
        test_key_lengths();
        test_backpressure();
        test_random_messages();
        test_steady_stream();

        // Wait out the last characters plus a short quiet period.
        settle();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_chars.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
